@@ hw/rtl/assert_macros.svh @@
// Assertion macros for the RTL files of the motor ramp controller.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Check prop on every rising clk edge, skipped while rst_n is low.
`define MSRC_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("msrc assertion failed");
// Check prop on every rising clk edge, reset cycles included.
`define MSRC_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("msrc assertion failed");
`else
`define MSRC_ASSERT(lbl, clk, rst_n, prop)
`define MSRC_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

@@ hw/rtl/msrc_pkg.sv @@
// Types and constants for the motor speed ramp controller.
// No dependencies; imported by msrc_div and the top level.
`timescale 1ns / 1ps
package msrc_pkg;

    // Field widths
    localparam int SPEED_W    = 7;
    localparam int DUTY_W     = 8;
    localparam int DIR_W      = 2;
    localparam int RAMP_W     = 16;
    localparam int DELAY_W    = 10;
    localparam int STEP_W     = 7;
    localparam int CMD_W      = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    // Divider: 7 bit speed delta times 16 bit elapsed time over 16 bit length
    localparam int DIV_NUM_W = SPEED_W + RAMP_W;
    localparam int DIV_DEN_W = RAMP_W;

    // Duty scaling: speed * 255 / 100 as speed * 2.55 in Q2.16 fixed point,
    // exact after truncation for speeds 0..100
    localparam int                       DUTY_RECIP_W = 18;
    localparam int                       DUTY_PROD_W  = SPEED_W + DUTY_RECIP_W;
    localparam int                       DUTY_SHIFT   = 16;
    localparam logic [DUTY_RECIP_W-1:0]  DUTY_RECIP   = 18'd167117;

    localparam logic [SPEED_W-1:0] SPEED_MAX = 7'd100;
    localparam logic [DELAY_W-1:0] DELAY_RST = 10'd20;
    localparam logic [STEP_W-1:0]  STEP_RST  = 7'd1;

    // Direction codes
    localparam logic [DIR_W-1:0] DIR_STOP  = 2'd0;
    localparam logic [DIR_W-1:0] DIR_LEFT  = 2'd1;
    localparam logic [DIR_W-1:0] DIR_RIGHT = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SMOOTH_DELAY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SMOOTH_STEP  = 2'd1;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_TICK  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_ON    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_OFF   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_SPEED = 3'd3;
    localparam logic [CMD_W-1:0] CMD_DIR   = 3'd4;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EXEC,
        ST_RAMP_MUL,
        ST_RAMP_GO,
        ST_RAMP_WAIT,
        ST_CHK,
        ST_DUTY_GO,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_DEN_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic                 busy;
        logic                 done;
        logic [DIV_NUM_W-1:0] quot;
    } t_div_rsp;

endpackage

@@ hw/rtl/msrc_div.sv @@
// Restoring serial divider, one quotient bit per cycle, used for the timed ramp point.
// Depends on msrc_pkg (widths and request/response structs).
`timescale 1ns / 1ps
module msrc_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  msrc_pkg::t_div_req i_req,
    output msrc_pkg::t_div_rsp o_rsp
);
    import msrc_pkg::*;

    localparam int CNT_W = $clog2(DIV_NUM_W);

    logic                 r_busy, n_busy;
    logic                 r_done, n_done;
    logic [CNT_W-1:0]     r_cnt, n_cnt;
    logic [DIV_NUM_W-1:0] r_quo, n_quo;
    logic [DIV_DEN_W-1:0] r_rem, n_rem;
    logic [DIV_DEN_W-1:0] r_den, n_den;
    logic [DIV_DEN_W:0]   rem_sh;
    logic                 ge;

    always_comb begin
        rem_sh = {r_rem, r_quo[DIV_NUM_W-1]};
        ge     = (rem_sh >= {1'b0, r_den});
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_den  = r_den;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_W'(DIV_NUM_W - 1);
            n_quo  = i_req.num;
            n_rem  = '0;
            n_den  = i_req.den;
        end else if (r_busy) begin
            n_quo = {r_quo[DIV_NUM_W-2:0], ge};
            n_rem = ge ? DIV_DEN_W'(rem_sh - {1'b0, r_den}) : rem_sh[DIV_DEN_W-1:0];
            n_cnt = r_cnt - CNT_W'(1);
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_den <= n_den;
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quo;

endmodule

@@ hw/rtl/motor_speed_ramp_controller_core.sv @@
// Top level of the motor speed ramp controller: command sequencer and channel state.
// Depends on msrc_pkg, msrc_div and assert_macros.svh.
//
//  channel | handshake                    | payload
//  --------+------------------------------+---------------------------------------------
//  in      | i_in_valid / o_in_ready      | i_cmd, i_speed, i_speed_valid, i_dir, i_ramp_ms
//  out     | o_out_valid / i_out_ready    | o_accepted, o_left_duty, o_right_duty,
//          |                              | o_drive_enable, o_speed_now, o_speed_goal,
//          |                              | o_reversing, o_ramping
//  cfg     | i_cfg_we (no wait)           | i_cfg_idx, i_cfg_wdata
//
// An accepted request passes ST_EXEC, ST_DUTY_GO and ST_FIN; a tick that reaches an
// update time adds ST_CHK, and a tick that advances a timed ramp also passes ST_RAMP_MUL,
// ST_RAMP_GO and ST_RAMP_WAIT, where the serial divider sets the long case.
// One request is in flight at a time; o_in_ready is high only while the sequencer idles,
// and a request is taken even while the previous result still waits on the output.
// A stalled output holds the sequencer in its final state until the result is taken.
// Reset is synchronous and active low, and needs no clearing pass.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module motor_speed_ramp_controller_core #(
    parameter int TIME_BITS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // request channel
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [msrc_pkg::CMD_W-1:0]     i_cmd,
    input  logic [msrc_pkg::SPEED_W-1:0]   i_speed,
    input  logic                           i_speed_valid,
    input  logic [msrc_pkg::DIR_W-1:0]     i_dir,
    input  logic [msrc_pkg::RAMP_W-1:0]    i_ramp_ms,
    // result channel
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic                           o_accepted,
    output logic [msrc_pkg::DUTY_W-1:0]    o_left_duty,
    output logic [msrc_pkg::DUTY_W-1:0]    o_right_duty,
    output logic                           o_drive_enable,
    output logic [msrc_pkg::SPEED_W-1:0]   o_speed_now,
    output logic [msrc_pkg::SPEED_W-1:0]   o_speed_goal,
    output logic                           o_reversing,
    output logic                           o_ramping,
    // configuration write port
    input  logic                           i_cfg_we,
    input  logic [msrc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [msrc_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);
    import msrc_pkg::*;

    localparam int CMP_W = (TIME_BITS > DELAY_W) ? TIME_BITS : DELAY_W;

    t_state r_state, n_state;

    // captured request
    logic [CMD_W-1:0]   r_cmd;
    logic [SPEED_W-1:0] r_spd;
    logic               r_spd_ok;
    logic [DIR_W-1:0]   r_dir_in;
    logic [RAMP_W-1:0]  r_ramp_in;

    // configuration
    logic [DELAY_W-1:0] r_delay, n_delay;
    logic [STEP_W-1:0]  r_step, n_step;

    // channel state
    logic                 r_en, n_en;
    logic [DIR_W-1:0]     r_dir_now, n_dir_now;
    logic [DIR_W-1:0]     r_dir_next, n_dir_next;
    logic [SPEED_W-1:0]   r_cur, n_cur;
    logic [SPEED_W-1:0]   r_tgt, n_tgt;
    logic [SPEED_W-1:0]   r_cmd_spd, n_cmd_spd;
    logic [SPEED_W-1:0]   r_resume, n_resume;
    logic                 r_rev, n_rev;
    logic                 r_ramp_on, n_ramp_on;
    logic [SPEED_W-1:0]   r_start, n_start;
    logic [RAMP_W-1:0]    r_len, n_len;
    logic [RAMP_W-1:0]    r_elapsed, n_elapsed;
    logic [TIME_BITS-1:0] r_ticks, n_ticks;
    logic                 r_acc, n_acc;

    // datapath scratch
    logic [DIV_NUM_W-1:0] r_prod, n_prod;
    logic                 r_neg, n_neg;
    logic [DUTY_W-1:0]    r_duty, n_duty;

    // result register
    logic               r_out_valid, n_out_valid;
    logic               r_o_acc;
    logic [DUTY_W-1:0]  r_o_left, r_o_right;
    logic               r_o_en;
    logic [SPEED_W-1:0] r_o_cur, r_o_tgt;
    logic               r_o_rev, r_o_ramp;
    logic               load_out;

    t_div_req div_req;
    t_div_rsp div_rsp;

    // tick scratch
    logic [TIME_BITS-1:0]   t1;
    logic [RAMP_W-1:0]      e1;
    logic                   due;
    logic                   rev2, ramp2;
    logic [SPEED_W-1:0]     tgt2;
    logic [SPEED_W:0]       up8, dn8;
    logic [SPEED_W-1:0]     mag, q7, clamp;
    logic [DUTY_PROD_W-1:0] duty_prod;
    logic                   dir_ok;

    msrc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign o_in_ready = (r_state == ST_IDLE);

    // Configuration decode
    always_comb begin
        n_delay = r_delay;
        n_step  = r_step;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SMOOTH_DELAY: n_delay = i_cfg_wdata[DELAY_W-1:0];
                CFG_SMOOTH_STEP:  n_step  = i_cfg_wdata[STEP_W-1:0];
                default: ;
            endcase
        end
    end

    // Divider request: ramp point, |delta| * elapsed over the ramp length
    always_comb begin
        div_req.start = (r_state == ST_RAMP_GO);
        div_req.num   = r_prod;
        div_req.den   = r_len;
    end

    // Sequencer: next state and channel state updates
    always_comb begin
        n_state    = r_state;
        n_en       = r_en;
        n_dir_now  = r_dir_now;
        n_dir_next = r_dir_next;
        n_cur      = r_cur;
        n_tgt      = r_tgt;
        n_cmd_spd  = r_cmd_spd;
        n_resume   = r_resume;
        n_rev      = r_rev;
        n_ramp_on  = r_ramp_on;
        n_start    = r_start;
        n_len      = r_len;
        n_elapsed  = r_elapsed;
        n_ticks    = r_ticks;
        n_acc      = r_acc;
        n_prod     = r_prod;
        n_neg      = r_neg;
        n_duty     = r_duty;
        load_out   = 1'b0;

        t1    = (r_ticks == '1) ? r_ticks : r_ticks + TIME_BITS'(1);
        e1    = (r_elapsed == '1) ? r_elapsed : r_elapsed + RAMP_W'(1);
        due   = (CMP_W'(t1) >= CMP_W'(r_delay)) || (t1 == '1);
        rev2  = r_rev;
        ramp2 = r_ramp_on;
        tgt2  = r_tgt;
        up8   = '0;
        dn8   = '0;
        mag   = (r_tgt < r_start) ? r_start - r_tgt : r_tgt - r_start;
        q7    = div_rsp.quot[SPEED_W-1:0];
        dir_ok = (r_dir_in == DIR_LEFT) || (r_dir_in == DIR_RIGHT);
        // speed * 255 / 100 by reciprocal multiply
        clamp     = (r_cur > SPEED_MAX) ? SPEED_MAX : r_cur;
        duty_prod = DUTY_PROD_W'(clamp) * DUTY_PROD_W'(DUTY_RECIP);

        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_EXEC;
            end

            ST_EXEC: begin
                n_state = ST_DUTY_GO;
                n_acc   = 1'b0;
                case (r_cmd)
                    CMD_TICK: begin
                        n_acc     = 1'b1;
                        n_ticks   = t1;
                        n_elapsed = e1;
                        if (due) begin
                            n_state = ST_CHK;
                            // reversal: run down to zero, then flip and resume
                            if (r_rev) begin
                                if (r_cur == '0) begin
                                    n_dir_now = r_dir_next;
                                    tgt2      = r_resume;
                                    rev2      = 1'b0;
                                end else begin
                                    tgt2  = '0;
                                    ramp2 = 1'b0;
                                end
                            end
                            n_tgt     = tgt2;
                            n_rev     = rev2;
                            n_ramp_on = ramp2;
                            if (ramp2 && !rev2) begin
                                n_ticks = '0;
                                if (e1 >= r_len) begin
                                    n_cur     = tgt2;
                                    n_ramp_on = 1'b0;
                                end else begin
                                    n_state = ST_RAMP_MUL;
                                end
                            end else if (r_cur != tgt2) begin
                                n_ticks = '0;
                                if (r_cur < tgt2) begin
                                    up8   = {1'b0, r_cur} + {1'b0, r_step};
                                    n_cur = (up8 < {1'b0, tgt2}) ? up8[SPEED_W-1:0] : tgt2;
                                end else begin
                                    dn8   = {1'b0, tgt2} + {1'b0, r_step};
                                    n_cur = ({1'b0, r_cur} > dn8) ? r_cur - r_step : tgt2;
                                end
                            end
                        end
                    end
                    CMD_ON: begin
                        if (r_spd_ok && (r_spd != '0) && dir_ok) begin
                            n_acc     = 1'b1;
                            n_en      = 1'b1;
                            n_cmd_spd = r_spd;
                            if ((r_cur != '0) && (r_dir_now != r_dir_in)) begin
                                n_rev      = 1'b1;
                                n_dir_next = r_dir_in;
                                n_resume   = r_spd;
                                n_tgt      = '0;
                                n_ramp_on  = 1'b0;
                            end else begin
                                n_dir_now = r_dir_in;
                                n_rev     = 1'b0;
                                n_tgt     = r_spd;
                                n_ramp_on = (r_ramp_in != '0);
                                if (r_ramp_in != '0) begin
                                    n_len     = r_ramp_in;
                                    n_elapsed = '0;
                                    n_start   = r_cur;
                                end
                            end
                        end
                    end
                    CMD_OFF: begin
                        n_acc = 1'b1;
                        if (r_en) begin
                            n_tgt      = '0;
                            n_cmd_spd  = '0;
                            n_ramp_on  = 1'b0;
                            n_rev      = 1'b0;
                            n_resume   = '0;
                            n_dir_next = DIR_STOP;
                        end
                    end
                    CMD_SPEED: begin
                        if (r_en && r_spd_ok) begin
                            n_acc     = 1'b1;
                            n_cmd_spd = r_spd;
                            n_tgt     = r_spd;
                            n_ramp_on = 1'b0;
                            if (r_spd == '0) begin
                                n_rev      = 1'b0;
                                n_resume   = '0;
                                n_dir_next = DIR_STOP;
                            end
                        end
                    end
                    CMD_DIR: begin
                        if (r_en && dir_ok) begin
                            n_acc = 1'b1;
                            if (r_dir_now != r_dir_in) begin
                                if (r_cur != '0) begin
                                    n_resume   = r_cmd_spd;
                                    n_dir_next = r_dir_in;
                                    n_rev      = 1'b1;
                                    n_tgt      = '0;
                                    n_ramp_on  = 1'b0;
                                end else begin
                                    n_dir_now = r_dir_in;
                                end
                            end
                        end
                    end
                    default: ;
                endcase
            end

            ST_RAMP_MUL: begin
                // |target - start| * elapsed; sign applied after the divide
                n_neg   = (r_tgt < r_start);
                n_prod  = DIV_NUM_W'(mag) * DIV_NUM_W'(r_elapsed);
                n_state = ST_RAMP_GO;
            end

            ST_RAMP_GO: n_state = ST_RAMP_WAIT;

            ST_RAMP_WAIT: begin
                if (div_rsp.done) begin
                    n_cur   = r_neg ? r_start - q7 : r_start + q7;
                    n_state = ST_CHK;
                end
            end

            ST_CHK: begin
                // controlled stop complete: drop the enable
                if (r_en && (r_cur == '0) && (r_tgt == '0) && (r_cmd_spd == '0)
                        && !r_rev && !r_ramp_on) begin
                    n_en       = 1'b0;
                    n_dir_now  = DIR_STOP;
                    n_dir_next = DIR_STOP;
                    n_resume   = '0;
                    n_ticks    = '0;
                end
                n_state = ST_DUTY_GO;
            end

            ST_DUTY_GO: begin
                // latch the duty of the final speed
                n_duty  = duty_prod[DUTY_SHIFT +: DUTY_W];
                n_state = ST_FIN;
            end

            ST_FIN: begin
                // hold until the result register is free
                if (!r_out_valid || i_out_ready) begin
                    load_out = 1'b1;
                    n_state  = ST_IDLE;
                end
            end

            default: n_state = ST_IDLE;
        endcase

        if (load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_delay     <= DELAY_RST;
            r_step      <= STEP_RST;
            r_en        <= 1'b0;
            r_dir_now   <= DIR_STOP;
            r_dir_next  <= DIR_STOP;
            r_cur       <= '0;
            r_tgt       <= '0;
            r_cmd_spd   <= '0;
            r_resume    <= '0;
            r_rev       <= 1'b0;
            r_ramp_on   <= 1'b0;
            r_start     <= '0;
            r_len       <= '0;
            r_elapsed   <= '0;
            r_ticks     <= '1;
            r_acc       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_delay     <= n_delay;
            r_step      <= n_step;
            r_en        <= n_en;
            r_dir_now   <= n_dir_now;
            r_dir_next  <= n_dir_next;
            r_cur       <= n_cur;
            r_tgt       <= n_tgt;
            r_cmd_spd   <= n_cmd_spd;
            r_resume    <= n_resume;
            r_rev       <= n_rev;
            r_ramp_on   <= n_ramp_on;
            r_start     <= n_start;
            r_len       <= n_len;
            r_elapsed   <= n_elapsed;
            r_ticks     <= n_ticks;
            r_acc       <= n_acc;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers: capture the request, scratch, and the result
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_cmd     <= i_cmd;
            r_spd     <= (i_speed > SPEED_MAX) ? SPEED_MAX : i_speed;
            r_spd_ok  <= i_speed_valid;
            r_dir_in  <= i_dir;
            r_ramp_in <= i_ramp_ms;
        end
        r_prod <= n_prod;
        r_neg  <= n_neg;
        r_duty <= n_duty;
        if (load_out) begin
            r_o_acc   <= r_acc;
            r_o_left  <= ((r_cur != '0) && (r_dir_now == DIR_LEFT)) ? r_duty : '0;
            r_o_right <= ((r_cur != '0) && (r_dir_now == DIR_RIGHT)) ? r_duty : '0;
            r_o_en    <= r_en;
            r_o_cur   <= r_cur;
            r_o_tgt   <= r_tgt;
            r_o_rev   <= r_rev;
            r_o_ramp  <= r_ramp_on;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_accepted     = r_o_acc;
    assign o_left_duty    = r_o_left;
    assign o_right_duty   = r_o_right;
    assign o_drive_enable = r_o_en;
    assign o_speed_now    = r_o_cur;
    assign o_speed_goal   = r_o_tgt;
    assign o_reversing    = r_o_rev;
    assign o_ramping      = r_o_ramp;

    // A taken request blocks further requests on the next cycle
    `MSRC_ASSERT(a_busy_after_req, i_clk, i_rst_n, (i_in_valid && o_in_ready) |=> !o_in_ready)
    // The divider is never restarted mid-division
    `MSRC_ASSERT(a_div_no_overlap, i_clk, i_rst_n, div_req.start |-> !div_rsp.busy)
    // Only one side of the bridge is ever driven
    `MSRC_ASSERT(a_one_side, i_clk, i_rst_n, o_out_valid |-> ((o_left_duty == '0) || (o_right_duty == '0)))
    // A reversal cancels any timed ramp
    `MSRC_ASSERT(a_rev_no_ramp, i_clk, i_rst_n, o_out_valid |-> !(o_reversing && o_ramping))
    // Reset drops any pending result
    `MSRC_ASSERT_ALWAYS(a_reset_clears, i_clk, !i_rst_n |=> !o_out_valid)

endmodule
